@@ rtl/eucd3_pkg.sv @@
package eucd3_pkg;

  // Three axes per point.
  localparam int NUM_AXES = 3;
  localparam int AXIS_X   = 0;
  localparam int AXIS_Y   = 1;
  localparam int AXIS_Z   = 2;

endpackage

@@ rtl/eucd3_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, truncating.
module eucd3_sqrt
  import eucd3_pkg::*;
#(
  parameter int ROOT_WIDTH = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2*ROOT_WIDTH-1:0]   radicand,
  output logic                      out_valid,
  output logic [ROOT_WIDTH-1:0]     root
);

  localparam int RAD_W = 2 * ROOT_WIDTH;
  localparam int REM_W = ROOT_WIDTH + 2;

  // Stage registers
  logic [RAD_W-1:0]      rad_q  [ROOT_WIDTH];
  logic [REM_W-1:0]      rem_q  [ROOT_WIDTH];
  logic [ROOT_WIDTH-1:0] root_q [ROOT_WIDTH];
  logic                  vld_q  [ROOT_WIDTH];

  // Stage inputs
  logic [RAD_W-1:0]      rad_in  [ROOT_WIDTH];
  logic [REM_W-1:0]      rem_in  [ROOT_WIDTH];
  logic [ROOT_WIDTH-1:0] root_in [ROOT_WIDTH];
  logic                  vld_in  [ROOT_WIDTH];

  for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rad_in[k]  = radicand;
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign vld_in[k]  = in_valid;
    end else begin : g_next
      assign rad_in[k]  = rad_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign vld_in[k]  = vld_q[k-1];
    end

    // Bring down the next two radicand bits; remainder fits in ROOT_WIDTH bits here.
    assign rem_sh = {rem_in[k][ROOT_WIDTH-1:0], rad_in[k][RAD_W-1 -: 2]};
    assign trial  = {root_in[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= {rad_in[k][RAD_W-3:0], 2'b00};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[k][ROOT_WIDTH-2:0], ge};
      end
    end
  end

  assign out_valid = vld_q[ROOT_WIDTH-1];
  assign root      = root_q[ROOT_WIDTH-1];

endmodule

@@ rtl/euclidean_distance_3d_top.sv @@
// Euclidean distance between two 3D points in signed fixed point. Each transfer on the
// input carries points a and b (COORD_WIDTH-bit two's complement coordinates, any
// fraction scale); the block returns the truncated square root of the exact sum of
// squared axis differences as an unsigned COORD_WIDTH+1 bit value in the same scale.
// One transfer in and one result out per cycle, sustained while out_stall stays low.
// The pipe has three stages for subtract, square and add, then one stage per root bit
// in the square-root pipeline. A two-entry output (pipe end plus skid register) lets
// one more item in while a result waits; after that in_stall rises until the result
// is taken. No state carries between items; reset only clears valids.
module euclidean_distance_3d_top
  import eucd3_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] a_z,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] b_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_WIDTH:0]          distance
);

  localparam int MAG_W = COORD_WIDTH + 1;  // |a-b| up to 2^COORD_WIDTH-1
  localparam int SQ_W  = 2 * MAG_W;        // sum of three squares fits here

  logic signed [COORD_WIDTH-1:0] a_pt [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] b_pt [NUM_AXES];

  assign a_pt[AXIS_X] = a_x;
  assign a_pt[AXIS_Y] = a_y;
  assign a_pt[AXIS_Z] = a_z;
  assign b_pt[AXIS_X] = b_x;
  assign b_pt[AXIS_Y] = b_y;
  assign b_pt[AXIS_Z] = b_z;

  // Whole pipe moves together; it freezes only while the skid register holds a result.
  logic advance;
  logic skid_valid;
  logic [COORD_WIDTH:0] skid_dist;
  logic pipe_valid;
  logic [COORD_WIDTH:0] pipe_root;

  assign advance  = !skid_valid;
  assign in_stall = skid_valid;

  // Stage 1: axis differences, magnitude
  logic [MAG_W-1:0] mag [NUM_AXES];
  logic             s1_valid;
  // Stage 2: squares
  logic [SQ_W-1:0]  sq  [NUM_AXES];
  logic             s2_valid;
  // Stage 3: sum
  logic [SQ_W-1:0]  sum;
  logic             s3_valid;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    logic signed [MAG_W-1:0] diff;
    logic        [MAG_W-1:0] mag_next;

    assign diff     = {a_pt[i][COORD_WIDTH-1], a_pt[i]} - {b_pt[i][COORD_WIDTH-1], b_pt[i]};
    assign mag_next = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    always_ff @(posedge clk) begin
      if (advance) begin
        mag[i] <= mag_next;
        sq[i]  <= mag[i] * mag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum <= sq[AXIS_X] + sq[AXIS_Y] + sq[AXIS_Z];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  eucd3_sqrt #(
    .ROOT_WIDTH (MAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s3_valid),
    .radicand  (sum),
    .out_valid (pipe_valid),
    .root      (pipe_root)
  );

  // Skid register: catches the pipe-end result when the sink stalls while the pipe moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (pipe_valid && out_stall) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_dist <= pipe_root;
    end
  end

  assign out_valid = skid_valid | pipe_valid;
  assign distance  = skid_valid ? skid_dist : pipe_root;

endmodule
